[hdl/aspd_pkg.sv]
// Shared constants, codes and the column word type for the pair distance unit.
package aspd_pkg;

  localparam int MAX_LEN_DEF     = 65536;
  localparam int SYMBOL_BITS_DEF = 5;
  localparam int QUEUE_DEPTH     = 4;

  localparam int CHAR_W    = 8;
  localparam int SCORE_W   = 24;
  localparam int DIST_W    = 48;
  localparam int KIND_W    = 2;
  localparam int FRAC_BITS = 16;

  localparam logic [CHAR_W-1:0] GAP_CHAR = 8'h2D;
  localparam logic [CHAR_W-1:0] UNK_CHAR = 8'h4E;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_COLUMN = 1'b1;

  localparam logic [KIND_W-1:0] KIND_RAW       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FRAC      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MIS_SCORE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ALL_SCORE = 2'd3;

  // one classified column on its way from the front to the back
  typedef struct packed {
    logic                      site;
    logic                      mis;
    logic                      last;
    logic signed [SCORE_W-1:0] entry;
  } col_t;

endpackage

[hdl/aspd_ram.sv]
// Generic single-port-write, registered-read RAM.
module aspd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/aspd_fifo.sv]
// Short queue of classified column words between front and back.
module aspd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  aspd_pkg::col_t din,
  output logic          full,
  input  logic          pop,
  output aspd_pkg::col_t dout,
  output logic          empty
);

  localparam int DEPTH = aspd_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  aspd_pkg::col_t    slots [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/aspd_front.sv]
// Front end: takes input words, writes the score table, classifies columns.
module aspd_front #(
  parameter int SYMBOL_BITS = aspd_pkg::SYMBOL_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic                               mode,
  input  logic [aspd_pkg::CHAR_W-1:0]        ref_char,
  input  logic [aspd_pkg::CHAR_W-1:0]        qry_char,
  input  logic signed [aspd_pkg::SCORE_W-1:0] score,
  input  logic                               last,
  input  logic                               q_full,
  output logic                               q_push,
  output aspd_pkg::col_t                     q_data
);

  localparam int AW    = 2 * SYMBOL_BITS;
  localparam int DEPTH = 1 << AW;

  logic                         accept;
  logic                         tbl_we;
  logic                         tbl_re;
  logic [AW-1:0]                tbl_addr;
  logic [aspd_pkg::SCORE_W-1:0] tbl_rdata;
  logic                         col_site;

  // stage holding a column while its table entry is read
  logic s1_valid;
  logic s1_site;
  logic s1_mis;
  logic s1_last;

  assign full     = s1_valid && q_full;
  assign accept   = push && !full;
  assign tbl_we   = accept && (mode == aspd_pkg::MODE_WRITE);
  assign tbl_re   = accept && (mode == aspd_pkg::MODE_COLUMN);
  assign tbl_addr = {ref_char[SYMBOL_BITS-1:0], qry_char[SYMBOL_BITS-1:0]};
  assign col_site = (ref_char != aspd_pkg::GAP_CHAR) && (qry_char != aspd_pkg::GAP_CHAR) &&
                    (ref_char != aspd_pkg::UNK_CHAR) && (qry_char != aspd_pkg::UNK_CHAR);

  aspd_ram #(
    .WIDTH (aspd_pkg::SCORE_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_addr),
    .wdata (score),
    .re    (tbl_re),
    .raddr (tbl_addr),
    .rdata (tbl_rdata)
  );

  assign q_push = s1_valid && !q_full;
  always_comb begin
    q_data.site  = s1_site;
    q_data.mis   = s1_mis;
    q_data.last  = s1_last;
    q_data.entry = tbl_rdata;
  end

  always_ff @(posedge clk) begin
    if (tbl_re) begin
      s1_site <= col_site;
      s1_mis  <= (ref_char != qry_char);
      s1_last <= last;
    end
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tbl_re) begin
      s1_valid <= 1'b1;
    end else if (q_push) begin
      s1_valid <= 1'b0;
    end
  end

endmodule

[hdl/aspd_back.sv]
// Back end: accumulators, shared-site divider and the result register.
module aspd_back #(
  parameter int MAX_LEN = aspd_pkg::MAX_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [aspd_pkg::KIND_W-1:0]         dist_kind,
  input  logic                                q_empty,
  input  aspd_pkg::col_t                      q_data,
  output logic                                q_pop,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [aspd_pkg::DIST_W-1:0]  distance,
  output logic                                no_shared_sites
);

  localparam int DW  = aspd_pkg::DIST_W;
  localparam int SW  = aspd_pkg::SCORE_W;
  localparam int CW  = $clog2(MAX_LEN + 1);
  localparam int QW  = aspd_pkg::FRAC_BITS + 1;
  localparam int SCW = $clog2(QW + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_LEN);
  localparam logic [DW-1:0] SUM_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SUM_MIN = {1'b1, {(DW-1){1'b0}}};

  logic [CW-1:0] mis_count;
  logic [CW-1:0] site_count;
  logic [DW-1:0] score_sum;

  logic [CW-1:0] mis_upd;
  logic [CW-1:0] site_upd;
  logic [DW-1:0] sum_upd;
  logic [DW:0]   sum_wide;
  logic          add_en;

  logic          out_valid;
  logic          out_set;

  logic          div_busy;
  logic          div_first;
  logic [SCW-1:0] div_cnt;
  logic [CW:0]   div_rem;
  logic [CW-1:0] div_den;
  logic [QW-1:0] div_quo;
  logic [CW:0]   trial;
  logic          trial_ge;
  logic [CW:0]   rem_next;
  logic [QW-1:0] quo_next;

  // a last word waits until the divider and the result register are free
  assign q_pop = !q_empty && (!q_data.last || (!div_busy && (!out_valid || pop)));
  assign empty = !out_valid;

  // result register loads when the divider finishes or a last word closes a pair directly
  assign out_set = (div_busy && (div_cnt == SCW'(1))) ||
                   (q_pop && q_data.last &&
                    !((dist_kind == aspd_pkg::KIND_FRAC) && (site_upd != '0)));

  always_comb begin
    mis_upd  = mis_count;
    site_upd = site_count;
    if (q_data.site) begin
      site_upd = (site_count >= CNT_MAX) ? CNT_MAX : site_count + 1'b1;
      if (q_data.mis) begin
        mis_upd = (mis_count >= CNT_MAX) ? CNT_MAX : mis_count + 1'b1;
      end
    end
    add_en = q_data.site && ((dist_kind == aspd_pkg::KIND_ALL_SCORE) ||
                             ((dist_kind == aspd_pkg::KIND_MIS_SCORE) && q_data.mis));
    sum_wide = {score_sum[DW-1], score_sum} +
               {{(DW+1-SW){q_data.entry[SW-1]}}, q_data.entry};
    if (!add_en) begin
      sum_upd = score_sum;
    end else if (sum_wide[DW] != sum_wide[DW-1]) begin
      sum_upd = sum_wide[DW] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_upd = sum_wide[DW-1:0];
    end
  end

  // restoring divide, one quotient bit a cycle; the first step takes no shift
  always_comb begin
    trial    = div_first ? div_rem : {div_rem[CW-1:0], 1'b0};
    trial_ge = (trial >= {1'b0, div_den});
    rem_next = trial_ge ? trial - {1'b0, div_den} : trial;
    quo_next = {div_quo[QW-2:0], trial_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mis_count  <= '0;
      site_count <= '0;
      score_sum  <= '0;
      out_valid  <= 1'b0;
      div_busy   <= 1'b0;
    end else begin
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (div_busy) begin
        div_first <= 1'b0;
        div_rem   <= rem_next;
        div_quo   <= quo_next;
        div_cnt   <= div_cnt - 1'b1;
        if (div_cnt == SCW'(1)) begin
          div_busy        <= 1'b0;
          distance        <= DW'(quo_next);
          no_shared_sites <= 1'b0;
        end
      end
      if (q_pop) begin
        if (q_data.last) begin
          mis_count  <= '0;
          site_count <= '0;
          score_sum  <= '0;
          case (dist_kind)
            aspd_pkg::KIND_RAW: begin
              distance        <= DW'(mis_upd) << aspd_pkg::FRAC_BITS;
              no_shared_sites <= 1'b0;
            end
            aspd_pkg::KIND_FRAC: begin
              if (site_upd == '0) begin
                distance        <= '0;
                no_shared_sites <= 1'b1;
              end else begin
                div_busy  <= 1'b1;
                div_first <= 1'b1;
                div_cnt   <= SCW'(QW);
                div_rem   <= {1'b0, mis_upd};
                div_den   <= site_upd;
                div_quo   <= '0;
              end
            end
            default: begin
              distance        <= sum_upd;
              no_shared_sites <= 1'b0;
            end
          endcase
        end else begin
          mis_count  <= mis_upd;
          site_count <= site_upd;
          score_sum  <= sum_upd;
        end
      end
    end
  end

endmodule

[hdl/aligned_sequence_pair_distance_unit.sv]
// Pair distance unit over aligned columns: one word per cycle in, one distance per pair out.
// A column word (mode 1) or a table write (mode 0) is taken every cycle while full is low;
// a column reaches the accumulators through the table read and then the four-word queue.
// Distances of kinds 0, 2 and 3 appear at the edge at which the last column leaves the queue;
// kind 1 runs a bit-serial divider, which overlaps with the columns of the next pair, so only
// a following last column waits for it. A kind 1 pair with fewer columns than the quotient
// has bits therefore sets the sustained rate. The score table holds 2^(2*SYMBOL_BITS) entries
// in one RAM and must be written before any column that reads it.
module aligned_sequence_pair_distance_unit #(
  parameter int MAX_LEN     = aspd_pkg::MAX_LEN_DEF,
  parameter int SYMBOL_BITS = aspd_pkg::SYMBOL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                dist_kind_we,
  input  logic [aspd_pkg::KIND_W-1:0]         dist_kind_wdata,
  input  logic                                push,
  output logic                                full,
  input  logic                                mode,
  input  logic [aspd_pkg::CHAR_W-1:0]         ref_char,
  input  logic [aspd_pkg::CHAR_W-1:0]         qry_char,
  input  logic signed [aspd_pkg::SCORE_W-1:0] score,
  input  logic                                last,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [aspd_pkg::DIST_W-1:0]  distance,
  output logic                                no_shared_sites
);

  logic [aspd_pkg::KIND_W-1:0] dist_kind;
  logic                        q_push;
  logic                        q_full;
  logic                        q_pop;
  logic                        q_empty;
  aspd_pkg::col_t              q_in;
  aspd_pkg::col_t              q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_kind <= aspd_pkg::KIND_RAW;
    end else if (dist_kind_we) begin
      dist_kind <= dist_kind_wdata;
    end
  end

  aspd_front #(
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .mode     (mode),
    .ref_char (ref_char),
    .qry_char (qry_char),
    .score    (score),
    .last     (last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  aspd_fifo u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  aspd_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .dist_kind       (dist_kind),
    .q_empty         (q_empty),
    .q_data          (q_out),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .distance        (distance),
    .no_shared_sites (no_shared_sites)
  );

  // flagged result always carries a zero distance
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && no_shared_sites) |-> (distance == '0))
    else $error("no_shared_sites set with non-zero distance");

  // queue never reports full and empty together
  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("queue full and empty at once");

  // a waiting result only leaves when it is popped
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    $rose(empty) |-> $past(pop))
    else $error("result word dropped without pop");

  // front stalls only while its queue is full
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    full |-> q_full)
    else $error("input stalled with room in the queue");

endmodule

[dv/aspd_checker.sv]
// Scoreboard for the pair distance unit: predicts every distance word and checks it on pop.
module aspd_checker
  import aspd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       dist_kind_we,
  input  logic [KIND_W-1:0]          dist_kind_wdata,
  input  logic                       push,
  input  logic                       full,
  input  logic                       mode,
  input  logic [CHAR_W-1:0]          ref_char,
  input  logic [CHAR_W-1:0]          qry_char,
  input  logic signed [SCORE_W-1:0]  score,
  input  logic                       last,
  input  logic                       empty,
  input  logic                       pop,
  input  logic signed [DIST_W-1:0]   distance,
  input  logic                       no_shared_sites,
  output int                         fails,
  output int                         outstanding
);

  localparam int SYM_W = SYMBOL_BITS_DEF;
  localparam int CNT_W = 17;
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(MAX_LEN_DEF);
  localparam logic signed [DIST_W-1:0] SUM_HI = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] SUM_LO = {1'b1, {(DIST_W-1){1'b0}}};

  typedef struct packed {
    logic signed [DIST_W-1:0] dist_val;
    logic                     no_sites;
  } dist_word_t;

  dist_word_t due_q[$];
  dist_word_t fresh, oldest;

  logic signed [SCORE_W-1:0] tbl [1 << (2*SYM_W)];
  logic [KIND_W-1:0]         kind_q;
  logic [CNT_W-1:0]          mis_cnt, site_cnt;
  logic signed [DIST_W-1:0]  sum_acc;
  logic signed [DIST_W:0]    wide;
  logic [2*SYM_W-1:0]        idx;
  logic                      is_mis;

  task automatic note_fail(input string msg);
    if (fails < 10) $display("%s", msg);
    fails++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      kind_q   = KIND_RAW;
      mis_cnt  = '0;
      site_cnt = '0;
      sum_acc  = '0;
      due_q.delete();
    end else begin
      // result side first: a word popped now was predicted at an earlier edge
      if (pop && !empty) begin
        if (due_q.size() == 0) begin
          note_fail($sformatf("unexpected distance word %0d flag %0b",
                              distance, no_shared_sites));
        end else begin
          oldest = due_q.pop_front();
          if (distance !== oldest.dist_val || no_shared_sites !== oldest.no_sites)
            note_fail($sformatf("distance mismatch: expected %0d flag %0b, got %0d flag %0b",
                                oldest.dist_val, oldest.no_sites, distance,
                                no_shared_sites));
        end
      end

      if (push && !full) begin
        idx = {ref_char[SYM_W-1:0], qry_char[SYM_W-1:0]};
        if (mode == MODE_WRITE) begin
          tbl[idx] = score;
        end else begin
          if (ref_char != GAP_CHAR && qry_char != GAP_CHAR &&
              ref_char != UNK_CHAR && qry_char != UNK_CHAR) begin
            is_mis = (ref_char != qry_char);
            if (site_cnt < CNT_CAP) site_cnt++;
            if (is_mis && mis_cnt < CNT_CAP) mis_cnt++;
            if (kind_q == KIND_ALL_SCORE || (kind_q == KIND_MIS_SCORE && is_mis)) begin
              wide = sum_acc + tbl[idx];
              if (wide[DIST_W] != wide[DIST_W-1])
                sum_acc = wide[DIST_W] ? SUM_LO : SUM_HI;
              else
                sum_acc = wide[DIST_W-1:0];
            end
          end
          if (last) begin
            fresh.no_sites = 1'b0;
            case (kind_q)
              KIND_RAW: fresh.dist_val = DIST_W'(mis_cnt) << FRAC_BITS;
              KIND_FRAC: begin
                if (site_cnt == '0) begin
                  fresh.dist_val = '0;
                  fresh.no_sites = 1'b1;
                end else begin
                  fresh.dist_val = (DIST_W'(mis_cnt) << FRAC_BITS) / DIST_W'(site_cnt);
                end
              end
              default: fresh.dist_val = sum_acc;
            endcase
            due_q.push_back(fresh);
            mis_cnt  = '0;
            site_cnt = '0;
            sum_acc  = '0;
          end
        end
      end

      if (dist_kind_we) kind_q = dist_kind_wdata;
    end
    outstanding <= due_q.size();
  end

endmodule

[dv/tb_aligned_sequence_pair_distance_unit.sv]
// Testbench top for the pair distance unit: clock, reset, column and table stimulus, verdict.
module tb_aligned_sequence_pair_distance_unit;
  import aspd_pkg::*;

  localparam int SYM_W        = SYMBOL_BITS_DEF;
  localparam int SETTLE       = 32;
  localparam int RANDOM_WORDS = 1900;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      dist_kind_we = 1'b0;
  logic [KIND_W-1:0]         dist_kind_wdata = '0;
  logic                      push = 1'b0;
  logic                      full;
  logic                      mode = MODE_WRITE;
  logic [CHAR_W-1:0]         ref_char = '0;
  logic [CHAR_W-1:0]         qry_char = '0;
  logic signed [SCORE_W-1:0] score = '0;
  logic                      last = 1'b0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic signed [DIST_W-1:0]  distance;
  logic                      no_shared_sites;
  int                        fails;
  int                        outstanding;

  int words_sent = 0;
  bit calm = 1'b0;
  bit loaded [1 << (2*SYM_W)];

  always #1 clk = ~clk;

  aligned_sequence_pair_distance_unit i_dut (
    .clk             (clk),
    .rst             (rst),
    .dist_kind_we    (dist_kind_we),
    .dist_kind_wdata (dist_kind_wdata),
    .push            (push),
    .full            (full),
    .mode            (mode),
    .ref_char        (ref_char),
    .qry_char        (qry_char),
    .score           (score),
    .last            (last),
    .empty           (empty),
    .pop             (pop),
    .distance        (distance),
    .no_shared_sites (no_shared_sites)
  );

  aspd_checker i_checker (.*);

  function automatic int gap_len();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SCORE_W-1:0] rand_score();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(SCORE_W-1){1'b1}}};
      1:       return {1'b1, {(SCORE_W-1){1'b0}}};
      2:       return '0;
      3:       return '1;
      default: return SCORE_W'($urandom);
    endcase
  endfunction

  function automatic int pair_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 16);
    if (roll < 95) return $urandom_range(17, 40);
    return $urandom_range(41, 200);
  endfunction

  // random column: gaps and N, matches, case-style mismatches and plain noise
  function automatic void pick_pair(output logic [CHAR_W-1:0] r, output logic [CHAR_W-1:0] q);
    int roll;
    roll = $urandom_range(0, 99);
    r = CHAR_W'($urandom);
    q = CHAR_W'($urandom);
    if (roll < 7)
      r = ($urandom_range(0, 1) != 0) ? GAP_CHAR : UNK_CHAR;
    else if (roll < 14)
      q = ($urandom_range(0, 1) != 0) ? GAP_CHAR : UNK_CHAR;
    else if (roll < 50)
      q = r;
    else if (roll < 62)
      q = r ^ (CHAR_W'($urandom_range(1, 7)) << SYM_W);
  endfunction

  task automatic push_word(input logic m, input logic [CHAR_W-1:0] r,
                           input logic [CHAR_W-1:0] q,
                           input logic signed [SCORE_W-1:0] s, input logic l);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push     <= 1'b1;
    mode     <= m;
    ref_char <= r;
    qry_char <= q;
    score    <= s;
    last     <= l;
    do @(posedge clk); while (full);
    words_sent++;
    if (m == MODE_WRITE) loaded[{r[SYM_W-1:0], q[SYM_W-1:0]}] = 1'b1;
  endtask

  task automatic load_entry(input logic [CHAR_W-1:0] r, input logic [CHAR_W-1:0] q);
    push_word(MODE_WRITE, r, q, rand_score(), 1'($urandom_range(0, 1)));
  endtask

  // table cell is loaded first if nothing has been written there yet
  task automatic put_column(input logic [CHAR_W-1:0] r, input logic [CHAR_W-1:0] q,
                            input logic l);
    if (!loaded[{r[SYM_W-1:0], q[SYM_W-1:0]}]) load_entry(r, q);
    push_word(MODE_COLUMN, r, q, SCORE_W'($urandom), l);
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_kind(input logic [KIND_W-1:0] k);
    drain();
    dist_kind_we    <= 1'b1;
    dist_kind_wdata <= k;
    @(posedge clk);
    dist_kind_we <= 1'b0;
  endtask

  task automatic run_pair(input int len, input bit closes);
    logic [CHAR_W-1:0] r, q;
    for (int i = 1; i <= len; i++) begin
      if ($urandom_range(0, 9) == 0) load_entry(CHAR_W'($urandom), CHAR_W'($urandom));
      pick_pair(r, q);
      put_column(r, q, closes && i == len);
    end
  endtask

  initial begin : sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop  <= 1'b1;
        hold = gap_len();
      end
    end
  end

  initial begin : stimulus
    logic [CHAR_W-1:0] r, q;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    set_kind(KIND_ALL_SCORE);
    push_word(MODE_WRITE, "A", "A", {1'b0, {(SCORE_W-1){1'b1}}}, 1'b0);
    // table write flagged last: no distance word
    push_word(MODE_WRITE, "A", "C", {1'b1, {(SCORE_W-1){1'b0}}}, 1'b1);
    put_column("A", "A", 1'b0);
    put_column("A", "C", 1'b0);
    put_column("a", "A", 1'b0);   // same cell as A/A, still a mismatch
    put_column(8'hFF, 8'h00, 1'b0);
    put_column(GAP_CHAR, "A", 1'b0);
    put_column("A", UNK_CHAR, 1'b1);

    set_kind(KIND_FRAC);
    put_column(GAP_CHAR, GAP_CHAR, 1'b1);   // nothing shared
    put_column("A", "C", 1'b0);
    put_column("A", "A", 1'b0);
    put_column(UNK_CHAR, UNK_CHAR, 1'b1);   // skipped column still closes the pair

    set_kind(KIND_MIS_SCORE);
    put_column("A", "C", 1'b0);
    put_column("a", "A", 1'b0);
    put_column(8'hFF, 8'h00, 1'b1);
    put_column("A", "C", 1'b0);   // pair stays open over the kind change
    set_kind(KIND_ALL_SCORE);
    put_column("A", "A", 1'b1);

    set_kind(KIND_RAW);
    put_column("C", "A", 1'b0);
    put_column(UNK_CHAR, "C", 1'b0);
    put_column("A", "A", 1'b1);

    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      set_kind(KIND_W'($urandom_range(0, 3)));
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 6)) run_pair(pair_len(), 1'b1);
      if ($urandom_range(0, 3) == 0) run_pair($urandom_range(1, 8), 1'b0);
      calm = 1'b0;
    end
    pick_pair(r, q);
    put_column(r, q, 1'b1);

    drain();
    if (fails == 0 && outstanding == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
